[rtl/tphw_pkg.sv]
// ----------------------------------------------------------------------------
// tphw_pkg
// Types, widths and constants shared by the tape pulse half-wave generator.
// ----------------------------------------------------------------------------
package tphw_pkg;

  // Width of the playback timer compare register.
  localparam int CMP_W      = 16;
  // Width of a pulse length in timer ticks.
  localparam int PULSE_W    = 25;
  // Working width for chunk compare and subtract; covers both widths above.
  localparam int CALC_W     = ((CMP_W > PULSE_W) ? CMP_W : PULSE_W) + 1;
  localparam logic [CALC_W-1:0] CHUNK_MAX = CALC_W'((64'd1 << CMP_W) - 64'd1);

  localparam int FRAC_W     = 12;
  localparam int LEN_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int LGAIN_W    = 13;
  localparam int PROD_W     = LEN_W + GAIN_W;

  localparam logic [GAIN_W-1:0]  SHORT_GAIN_RST = 16'd33260;
  localparam logic [LGAIN_W-1:0] LONG_GAIN_RST  = 13'd4157;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAIN  = 1'd1;

  // Stream bytes consumed per event.
  localparam logic [2:0] TAKEN_NONE  = 3'd0;
  localparam logic [2:0] TAKEN_SHORT = 3'd1;
  localparam logic [2:0] TAKEN_EXT   = 3'd4;

  typedef struct packed {
    logic       motor_on;
    logic [7:0] first_byte;
    logic [7:0] length_low;
    logic [7:0] length_mid;
    logic [7:0] length_high;
  } in_item_t;

  typedef struct packed {
    logic [15:0] compare_period;
    logic        line_level;
    logic [2:0]  bytes_taken;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  short_gain;
    logic [LGAIN_W-1:0] long_gain;
  } gains_t;

endpackage

[rtl/tphw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tphw_cfg_regs
// Gain registers written through the configuration channel.
// ----------------------------------------------------------------------------
module tphw_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tphw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tphw_pkg::CFG_DATA_W-1:0] cfg_data,
  output tphw_pkg::gains_t               gains
);
  import tphw_pkg::*;

  gains_t gain_regs;

  assign cfg_ready = 1'b1;
  assign gains     = gain_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_regs.short_gain <= SHORT_GAIN_RST;
      gain_regs.long_gain  <= LONG_GAIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHORT_GAIN: gain_regs.short_gain <= cfg_data[GAIN_W-1:0];
        CFG_LONG_GAIN:  gain_regs.long_gain  <= cfg_data[LGAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/tphw_engine.sv]
// ----------------------------------------------------------------------------
// tphw_engine
// Half-wave state and the per-event pulse arithmetic.
// ----------------------------------------------------------------------------
module tphw_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  tphw_pkg::in_item_t  item,
  input  tphw_pkg::gains_t    gains,
  output tphw_pkg::out_item_t result
);
  import tphw_pkg::*;

  logic [PULSE_W-1:0] remaining, remaining_next;
  logic [PULSE_W-1:0] saved, saved_next;
  logic               second, second_next;

  logic               load;
  logic               is_ext;
  logic [LEN_W-1:0]   op_a;
  logic [GAIN_W-1:0]  op_b;
  logic [PROD_W-1:0]  product;
  logic [PULSE_W-1:0] pulse;
  logic [CALC_W-1:0]  cur;
  logic [CALC_W-1:0]  period;

  always_comb begin
    load    = !second && (remaining == '0);
    is_ext  = (item.first_byte == 8'd0);
    // A zero code byte means the next three bytes hold a 24-bit length.
    op_a    = is_ext ? {item.length_high, item.length_mid, item.length_low}
                     : {{(LEN_W-8){1'b0}}, item.first_byte};
    op_b    = is_ext ? {{(GAIN_W-LGAIN_W){1'b0}}, gains.long_gain} : gains.short_gain;
    product = PROD_W'(op_a) * PROD_W'(op_b);
    pulse   = product[FRAC_W +: PULSE_W];
    saved_next = load ? pulse : saved;
    cur     = CALC_W'(load ? pulse : remaining);

    if (cur > CHUNK_MAX) begin
      period         = CHUNK_MAX;
      remaining_next = PULSE_W'(cur - CHUNK_MAX);
      second_next    = second;
    end else begin
      // Last chunk of a half-wave: the low half hands over to the high half, and the high half back to the low half.
      period         = cur;
      remaining_next = second ? '0 : saved_next;
      second_next    = !second;
    end

    result.compare_period = period[15:0];
    result.line_level     = second;
    if (!load) begin
      result.bytes_taken = TAKEN_NONE;
    end else if (is_ext) begin
      result.bytes_taken = TAKEN_EXT;
    end else begin
      result.bytes_taken = TAKEN_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      saved     <= '0;
      second    <= 1'b0;
    end else if (fire) begin
      remaining <= remaining_next;
      saved     <= saved_next;
      second    <= second_next;
    end
  end

endmodule

[rtl/tape_pulse_half_wave_generator_unit.sv]
// An accepted event waits in the input register; its result is then held in
// the result register, where output back-pressure can keep it.
// Throughput: one event per cycle while the output side keeps up; the pulse
// multiply, chunk compare and subtract sit between those two registers.
// Events with the motor line off produce no result and leave state as is.
// Reset (rst, synchronous): half-wave state cleared, gains to their defaults.
// ----------------------------------------------------------------------------
// tape_pulse_half_wave_generator_unit
// Turns timer compare events into low/high half-wave chunk periods.
// ----------------------------------------------------------------------------
module tape_pulse_half_wave_generator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tphw_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tphw_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tphw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tphw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tphw_pkg::*;

  gains_t    gains;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  logic      fire;
  out_item_t result;

  // The result register frees up whenever it is empty or being drained.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance && s1_item.motor_on;

  tphw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  tphw_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .gains  (gains),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid && s1_item.motor_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
    if (fire) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output side is ready");

  a_load_in_low_half: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bytes_taken != TAKEN_NONE) |-> !out_data.line_level)
    else $error("stream bytes taken during the high half-wave");

  a_taken_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.bytes_taken == TAKEN_NONE ||
                   out_data.bytes_taken == TAKEN_SHORT ||
                   out_data.bytes_taken == TAKEN_EXT))
    else $error("bad bytes_taken value");

  a_motor_off_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_item.motor_on && advance) |=> !out_valid)
    else $error("result produced for a motor-off event");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tape pulse half-wave generator. A directed
// table covers the extremes, zero-length pulses and exact chunk boundaries.
// Random phases under several gain settings follow it. Every result is checked
// against its row's typed expectation, if any, else a cycle-free software copy of the pulse state.
// ----------------------------------------------------------------------------
module tb_top;
  import tphw_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_PAD    = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_EVENTS = 215;

  typedef enum logic {ROW_GAINS, ROW_EVENT} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    in_item_t           item;
    logic [GAIN_W-1:0]  short_gain;
    logic [LGAIN_W-1:0] long_gain;
    logic               has_exp;
    out_item_t          exp_item;
  } plan_row_t;

  // Typed expectations assume the gains of the most recent gains row, or the reset gains before the first.
  localparam plan_row_t PLAN [25] = '{
    '{ROW_EVENT, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, '0, '0, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h01, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd8, 1'b0, TAKEN_SHORT}},
    '{ROW_EVENT, '{1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55}, '0, '0, 1'b1,
      '{16'd8, 1'b1, TAKEN_NONE}},
    '{ROW_EVENT, '{1'b1, 8'hFF, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd2070, 1'b0, TAKEN_SHORT}},
    '{ROW_EVENT, '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF}, '0, '0, 1'b1,
      '{16'd2070, 1'b1, TAKEN_NONE}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd0, 1'b0, TAKEN_EXT}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd0, 1'b1, TAKEN_NONE}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h01, 8'h00, 8'h01}, '0, '0, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h5A, 8'hA5, 8'h5A, 8'hA5}, '0, '0, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b0, '0},
    '{ROW_GAINS, '0, 16'd0, 13'd4096, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h80, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd0, 1'b0, TAKEN_SHORT}},
    '{ROW_EVENT, '{1'b1, 8'h80, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd0, 1'b1, TAKEN_NONE}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00}, '0, '0, 1'b1,
      '{16'd65535, 1'b0, TAKEN_EXT}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd65535, 1'b1, TAKEN_NONE}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h01}, '0, '0, 1'b1,
      '{16'd65535, 1'b0, TAKEN_EXT}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd1, 1'b0, TAKEN_NONE}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd65535, 1'b1, TAKEN_NONE}},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b1,
      '{16'd1, 1'b1, TAKEN_NONE}},
    '{ROW_GAINS, '0, 16'hFFFF, 13'h1FFF, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h55, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h55, 8'h00, 8'h00, 8'h00}, '0, '0, 1'b0, '0},
    '{ROW_EVENT, '{1'b1, 8'h00, 8'hAA, 8'h55, 8'h01}, '0, '0, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Side channel that travels with in_data: a typed expectation, if any.
  logic      ev_fixed;
  out_item_t ev_exp;

  // Pulse state and gains as the block should hold them.
  logic [PULSE_W-1:0] ticks_left;
  logic [PULSE_W-1:0] pulse_len;
  logic               second_half;
  logic [GAIN_W-1:0]  short_g;
  logic [LGAIN_W-1:0] long_g;

  out_item_t period_q[$];
  int        fails = 0;
  int        stall_cycles = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;

  tape_pulse_half_wave_generator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Emits one chunk of the running half-wave and, when it closes, moves on.
  function automatic logic [CMP_W-1:0] next_chunk(logic close_to_high);
    logic [CMP_W-1:0] period;
    if (ticks_left > CHUNK_MAX) begin
      ticks_left = ticks_left - PULSE_W'(CHUNK_MAX);
      period = CMP_W'(CHUNK_MAX);
    end else begin
      period = ticks_left[CMP_W-1:0];
      ticks_left = close_to_high ? pulse_len : '0;
      second_half = close_to_high;
    end
    return period;
  endfunction

  function automatic bit predict_period(in_item_t ev, output out_item_t res);
    logic [PROD_W-1:0] prod;
    res = '0;
    if (!ev.motor_on) return 1'b0;
    res.bytes_taken = TAKEN_NONE;
    if (second_half) begin
      res.line_level = 1'b1;
      res.compare_period = next_chunk(1'b0);
    end else begin
      if (ticks_left == '0) begin
        if (ev.first_byte == 8'h00) begin
          prod = PROD_W'({ev.length_high, ev.length_mid, ev.length_low}) * PROD_W'(long_g);
          res.bytes_taken = TAKEN_EXT;
        end else begin
          prod = PROD_W'(ev.first_byte) * PROD_W'(short_g);
          res.bytes_taken = TAKEN_SHORT;
        end
        pulse_len = prod[FRAC_W +: PULSE_W];
        ticks_left = pulse_len;
      end
      res.line_level = 1'b0;
      res.compare_period = next_chunk(1'b1);
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= 100)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t predicted;
    out_item_t want;
    if (rst) begin
      ticks_left  = '0;
      pulse_len   = '0;
      second_half = 1'b0;
      short_g     = SHORT_GAIN_RST;
      long_g      = LONG_GAIN_RST;
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (cfg_valid && cfg_ready) begin
        stall_cycles = 0;
        if (cfg_index == CFG_SHORT_GAIN) short_g = cfg_data;
        else long_g = cfg_data[LGAIN_W-1:0];
      end
      // A result always stems from an earlier transaction, so it is checked first.
      if (out_valid && out_ready) begin
        stall_cycles = 0;
        if (period_q.size() == 0) begin
          fails++;
          if (fails <= 100)
            $display({"%0t ns: unexpected result, expected none, ",
                      "actual period=%0d level=%0d taken=%0d"},
                     $time, out_data.compare_period, out_data.line_level,
                     out_data.bytes_taken);
        end else begin
          want = period_q.pop_front();
          check_field("compare_period", want.compare_period, out_data.compare_period);
          check_field("line_level", want.line_level, out_data.line_level);
          check_field("bytes_taken", want.bytes_taken, out_data.bytes_taken);
        end
      end
      if (in_valid && in_ready) begin
        stall_cycles = 0;
        if (predict_period(in_data, predicted))
          period_q.push_back(ev_fixed ? ev_exp : predicted);
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Result side: random back-pressure, one long hold-off on request.
  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic drive_event(in_item_t ev, logic fixed, out_item_t fixed_exp);
    in_valid <= 1'b1;
    in_data  <= ev;
    ev_fixed <= fixed;
    ev_exp   <= fixed_exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Each cycle idles with the same odds, so idle cycles make up about a third.
  task automatic pause_sender();
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits until every expected result is out, then lets the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (period_q.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Writes both gains back to back; valid stays high between the two transactions.
  task automatic set_gains(logic [GAIN_W-1:0] sg, logic [LGAIN_W-1:0] lg);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SHORT_GAIN;
    cfg_data  <= sg;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_LONG_GAIN;
    cfg_data  <= CFG_DATA_W'(lg);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t           ev;
    int unsigned        roll;
    logic [GAIN_W-1:0]  sg;
    logic [LGAIN_W-1:0] lg;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    ev_fixed  <= 1'b0;
    ev_exp    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SHORT_GAIN;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_GAINS) begin
        wait_drained();
        set_gains(PLAN[r].short_gain, PLAN[r].long_gain);
      end else begin
        pause_sender();
        drive_event(PLAN[r].item, PLAN[r].has_exp, PLAN[r].exp_item);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sg = GAIN_W'($urandom);
          lg = LGAIN_W'($urandom);
        end
        1: begin
          sg = '0;
          lg = '0;
        end
        2: begin
          sg = '1;
          lg = '1;
        end
        default: begin
          sg = SHORT_GAIN_RST;
          lg = LONG_GAIN_RST;
        end
      endcase
      wait_drained();
      set_gains(sg, lg);
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        // Lengths stay short most of the time so pulses finish in a few
        // chunks; with both gains at zero any length is cheap.
        roll = $urandom_range(99);
        ev.motor_on    = ($urandom_range(99) < 90);
        ev.first_byte  = $urandom_range(1) ? 8'($urandom) : 8'h00;
        ev.length_low  = 8'($urandom);
        ev.length_mid  = (ph == 1 || roll >= 70) ? 8'($urandom) : 8'($urandom_range(3));
        ev.length_high = (ph == 1) ? 8'($urandom) :
                         (roll >= 97) ? 8'($urandom_range(3)) : 8'h00;
        if (ph == 2 && i == 100) ev = '{1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF};
        if (ph == 0 && i == 60) hold_req = 1'b1;
        if (ph == 1 && i == 20) calm = 1'b1;
        if (ph == 1 && i == 170) calm = 1'b0;
        pause_sender();
        drive_event(ev, 1'b0, '0);
      end
    end

    wait_drained();
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
